// ===== hdl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator package
// Shared widths, register indexes, request codes and control structs.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int ADDR_W = 32;
	localparam int PAY_W  = 16;
	localparam int CNT_W  = 9;
	// payload plus a header of up to 65536 bytes
	localparam int BLK_W  = PAY_W + 1;
	// a valid offset lies below count * block
	localparam int REM_W  = CNT_W + BLK_W;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_SLOTS    = 256;
	localparam int DEF_HEADER_BYTES = 16;

	localparam logic [ADDR_W-1:0] RST_POOL_BASE     = '0;
	localparam logic [PAY_W-1:0]  RST_PAYLOAD_BYTES = PAY_W'(64);
	localparam logic [CNT_W-1:0]  RST_SLOT_COUNT    = CNT_W'(256);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_BASE     = 2'd0,
		CFG_PAYLOAD_BYTES = 2'd1,
		CFG_SLOT_COUNT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic pop_rd;
		logic pop_commit;
		logic push;
		logic take_fresh;
	} fl_ctrl_t;

	typedef struct packed {
		logic head_valid;
		logic fresh_avail;
	} fl_sts_t;

	typedef struct packed {
		logic mul_en;
		logic div_start;
	} ar_ctrl_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} ar_sts_t;

endpackage

// ===== hdl/fbpa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [fbpa_pkg::ADDR_W-1:0] address;

	modport source (output valid, output func, output address, input ready);
	modport sink (input valid, input func, input address, output ready);
endinterface

interface fbpa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [fbpa_pkg::ADDR_W-1:0] block_address;
	logic                        ok;

	modport source (output valid, output block_address, output ok, input ready);
	modport sink (input valid, input block_address, input ok, output ready);
endinterface

interface fbpa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fbpa_pkg::CFG_IDX_W-1:0] index;
	logic [fbpa_pkg::ADDR_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fbpa_freelist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list store
// LIFO of freed slots linked through a memory, plus a high-water mark of
// slots never handed out.
// ----------------------------------------------------------------------------
module fbpa_freelist #(
	parameter int MAX_SLOTS = fbpa_pkg::DEF_MAX_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fbpa_pkg::fl_ctrl_t          ctrl,
	input  logic [$clog2(MAX_SLOTS+1)-1:0] push_slot,
	input  logic [fbpa_pkg::CNT_W-1:0]  count,
	output logic [$clog2(MAX_SLOTS+1)-1:0] head,
	output logic [$clog2(MAX_SLOTS+1)-1:0] fresh,
	output fbpa_pkg::fl_sts_t           sts
);

	localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int CMP_W  = (SLOT_W > fbpa_pkg::CNT_W) ? SLOT_W : fbpa_pkg::CNT_W;

	logic [SLOT_W-1:0] link_mem [MAX_SLOTS];
	logic [SLOT_W-1:0] link_rd_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] hw_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			link_mem[push_slot[IDX_W-1:0]] <= head_q;
		end
		if (ctrl.pop_rd) begin
			link_rd_q <= link_mem[head_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= SLOT_W'(MAX_SLOTS);
			hw_q   <= '0;
		end else begin
			if (ctrl.pop_commit) begin
				head_q <= link_rd_q;
			end else if (ctrl.push) begin
				head_q <= push_slot;
			end
			if (ctrl.take_fresh) begin
				hw_q <= hw_q + SLOT_W'(1);
			end
		end
	end

	assign head             = head_q;
	assign fresh            = hw_q;
	assign sts.head_valid   = head_q < SLOT_W'(MAX_SLOTS);
	assign sts.fresh_avail  = CMP_W'(hw_q) < CMP_W'(count);

`ifndef ASSERT_OFF
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop_rd |-> sts.head_valid)
		else $error("pop issued on an empty freed list");
	a_fresh_only_when_list_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take_fresh |-> (sts.fresh_avail && !sts.head_valid))
		else $error("fresh slot taken while freed slots remain or none left");
	a_push_makes_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> sts.head_valid)
		else $error("pushed slot did not become a valid head");
`endif

endmodule

// ===== hdl/fbpa_arith.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One registered multiplier and an iterative restoring divider that
// produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_arith #(
	parameter int MUL_W = fbpa_pkg::CNT_W
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  fbpa_pkg::ar_ctrl_t                      ctrl,
	input  logic [MUL_W-1:0]                        mul_a,
	input  logic [fbpa_pkg::BLK_W-1:0]              block,
	input  logic [fbpa_pkg::REM_W-1:0]              dividend,
	output logic [MUL_W+fbpa_pkg::BLK_W-1:0]        prod,
	output logic [fbpa_pkg::CNT_W-1:0]              quotient,
	output fbpa_pkg::ar_sts_t                       sts
);

	localparam int PROD_W = MUL_W + fbpa_pkg::BLK_W;
	localparam int REM_W  = fbpa_pkg::REM_W;
	localparam int QW     = fbpa_pkg::CNT_W;
	localparam int DCNT_W = $clog2(QW + 1);

	logic [PROD_W-1:0] prod_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dvs_q;
	logic [QW-1:0]     quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W:0]    diff;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(block);
		end
	end

	assign diff = {1'b0, rem_q} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.div_start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is known to fit QW bits, so start with the divisor at the top bit
	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			rem_q <= dividend;
			dvs_q <= REM_W'(block) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (!diff[REM_W]) begin
				rem_q <= diff[REM_W-1:0];
			end
			quo_q <= {quo_q[QW-2:0], ~diff[REM_W]};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign prod         = prod_q;
	assign quotient     = quo_q;
	assign sts.div_busy = busy_q;
	assign sts.div_done = done_q;

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
// From request accept to response valid, a failed allocate goes straight to S_OUT;
// a fresh-slot allocate passes S_MUL and S_EVAL, one from the freed list S_POP,
// S_MUL and S_EVAL, and a free S_MUL, S_EVAL and, if in range, S_DIV.
// A request is accepted in the cycle after the previous response is loaded, so
// no new request is taken while one is in work.
// Reset is asynchronous: it empties the freed list, zeroes the high-water mark
// and loads the register defaults.
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Sequencer, configuration registers and response register around the free
// list store and the shared multiply/divide unit.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
	parameter int MAX_SLOTS    = fbpa_pkg::DEF_MAX_SLOTS,
	parameter int HEADER_BYTES = fbpa_pkg::DEF_HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	fbpa_cfg_if.sink    cfg,
	fbpa_req_if.sink    req,
	fbpa_rsp_if.source  rsp
);

	localparam int ADDR_W = fbpa_pkg::ADDR_W;
	localparam int PAY_W  = fbpa_pkg::PAY_W;
	localparam int CNT_W  = fbpa_pkg::CNT_W;
	localparam int BLK_W  = fbpa_pkg::BLK_W;
	localparam int REM_W  = fbpa_pkg::REM_W;
	localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
	localparam int MUL_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
	localparam int PROD_W = MUL_W + BLK_W;
	localparam int LIM_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
	localparam int EXT_W  = ADDR_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_MUL,
		S_EVAL,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] pool_base_q;
	logic [PAY_W-1:0]  payload_q;
	logic [CNT_W-1:0]  slot_count_q;

	logic              func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_ok_q;
	logic              rsp_valid_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic              rsp_ok_q;

	logic [BLK_W-1:0]  block;
	logic [CNT_W-1:0]  count;
	logic [EXT_W-1:0]  start;
	logic              below;
	logic [ADDR_W-1:0] off;
	logic              in_range;
	logic [MUL_W-1:0]  mul_a;
	logic              req_fire;
	logic              out_free;

	fbpa_pkg::fl_ctrl_t fl_ctrl;
	fbpa_pkg::fl_sts_t  fl_sts;
	fbpa_pkg::ar_ctrl_t ar_ctrl;
	fbpa_pkg::ar_sts_t  ar_sts;
	logic [SLOT_W-1:0]  head;
	logic [SLOT_W-1:0]  fresh;
	logic [SLOT_W-1:0]  push_slot;
	logic [PROD_W-1:0]  prod;
	logic [CNT_W-1:0]   quotient;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= fbpa_pkg::RST_POOL_BASE;
			payload_q    <= fbpa_pkg::RST_PAYLOAD_BYTES;
			slot_count_q <= fbpa_pkg::RST_SLOT_COUNT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				fbpa_pkg::CFG_POOL_BASE: begin
					pool_base_q <= cfg.data;
				end
				fbpa_pkg::CFG_PAYLOAD_BYTES: begin
					payload_q <= cfg.data[PAY_W-1:0];
				end
				fbpa_pkg::CFG_SLOT_COUNT: begin
					slot_count_q <= cfg.data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign block = BLK_W'(payload_q) + BLK_W'(HEADER_BYTES);
	assign count = (int'(slot_count_q) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : slot_count_q;

	// range test in exact arithmetic: no wrap past the top of the address space
	assign start    = {1'b0, pool_base_q} + EXT_W'(HEADER_BYTES);
	assign below    = {1'b0, addr_q} < start;
	assign off      = addr_q - start[ADDR_W-1:0];
	assign in_range = !below && (LIM_W'(off) < LIM_W'(prod));

	assign mul_a     = (func_q == fbpa_pkg::FUNC_ALLOC) ? MUL_W'(slot_q) : MUL_W'(count);
	assign push_slot = SLOT_W'(quotient);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	fbpa_freelist #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_freelist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fl_ctrl),
		.push_slot (push_slot),
		.count     (count),
		.head      (head),
		.fresh     (fresh),
		.sts       (fl_sts)
	);

	fbpa_arith #(
		.MUL_W (MUL_W)
	) u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ar_ctrl),
		.mul_a    (mul_a),
		.block    (block),
		.dividend (off[REM_W-1:0]),
		.prod     (prod),
		.quotient (quotient),
		.sts      (ar_sts)
	);

	always_comb begin
		fl_ctrl = '0;
		ar_ctrl = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.func == fbpa_pkg::FUNC_ALLOC) begin
					if (fl_sts.head_valid) begin
						fl_ctrl.pop_rd = 1'b1;
					end else if (fl_sts.fresh_avail) begin
						fl_ctrl.take_fresh = 1'b1;
					end
				end
			end
			S_POP: begin
				fl_ctrl.pop_commit = 1'b1;
			end
			S_MUL: begin
				ar_ctrl.mul_en = 1'b1;
			end
			S_EVAL: begin
				if (func_q == fbpa_pkg::FUNC_FREE && in_range) begin
					ar_ctrl.div_start = 1'b1;
				end
			end
			S_DIV: begin
				if (ar_sts.div_done) begin
					fl_ctrl.push = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.func == fbpa_pkg::FUNC_FREE) begin
							state_q <= S_MUL;
						end else if (fl_sts.head_valid) begin
							state_q <= S_POP;
						end else if (fl_sts.fresh_avail) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_POP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (func_q == fbpa_pkg::FUNC_FREE && in_range) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (ar_sts.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the response register is free
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					func_q     <= req.func;
					addr_q     <= req.address;
					slot_q     <= fl_sts.head_valid ? head : fresh;
					res_addr_q <= '0;
					res_ok_q   <= 1'b0;
				end
			end
			S_EVAL: begin
				if (func_q == fbpa_pkg::FUNC_ALLOC) begin
					res_addr_q <= pool_base_q + ADDR_W'(prod) + ADDR_W'(HEADER_BYTES);
					res_ok_q   <= 1'b1;
				end
			end
			S_DIV: begin
				if (ar_sts.div_done) begin
					res_ok_q <= 1'b1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					rsp_addr_q <= res_addr_q;
					rsp_ok_q   <= res_ok_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.ok            = rsp_ok_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request accepted while previous one still in work");
	a_div_only_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		ar_sts.div_busy |-> (state_q == S_DIV))
		else $error("divider running outside its sequencer state");
	a_nonzero_addr_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.block_address != '0) |-> rsp.ok)
		else $error("address returned on a failed or free response");
`endif

endmodule

// ===== sim/fixed_block_pool_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator checker
// Watches the configuration, request and response channels, keeps its own
// copy of the free list and pool registers, predicts each response and
// compares it field by field in order.
// ----------------------------------------------------------------------------
module fbpa_alloc_checker (
	input  logic       clk,
	input  logic       arst_n,
	fbpa_cfg_if        cfg,
	fbpa_req_if        req,
	fbpa_rsp_if        rsp,
	output int         failures,
	output int         pending,
	output int         grants,
	output int         reclaims
);

	localparam int ADDR_W = fbpa_pkg::ADDR_W;
	localparam int PAY_W  = fbpa_pkg::PAY_W;
	localparam int CNT_W  = fbpa_pkg::CNT_W;
	localparam int IDX_W  = $clog2(fbpa_pkg::DEF_MAX_SLOTS);

	localparam longint unsigned SLOT_LIMIT = fbpa_pkg::DEF_MAX_SLOTS;
	localparam longint unsigned HDR_BYTES  = fbpa_pkg::DEF_HEADER_BYTES;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		logic              ok;
	} alloc_result_t;

	// pool registers as last written
	logic [ADDR_W-1:0] pool_base;
	logic [PAY_W-1:0]  payload_sz;
	logic [CNT_W-1:0]  slot_lim;

	// freed-slot stack plus the mark of slots never handed out
	logic [CNT_W-1:0]  chain_next [fbpa_pkg::DEF_MAX_SLOTS];
	logic [CNT_W-1:0]  head_slot;
	logic [CNT_W-1:0]  fresh_mark;

	alloc_result_t     expected_q [$];
	int                fail_cnt;
	int                grant_cnt;
	int                reclaim_cnt;

	assign failures = fail_cnt;
	assign grants   = grant_cnt;
	assign reclaims = reclaim_cnt;

	function automatic alloc_result_t predict_request(input logic func_bit,
			input logic [ADDR_W-1:0] addr);
		alloc_result_t   res;
		longint unsigned usable;
		longint unsigned blk;
		longint unsigned start;
		longint unsigned off;
		longint unsigned slot;
		res    = '0;
		usable = (slot_lim > SLOT_LIMIT) ? SLOT_LIMIT : slot_lim;
		blk    = longint'(payload_sz) + HDR_BYTES;
		if (func_bit == fbpa_pkg::FUNC_ALLOC) begin
			if (head_slot < SLOT_LIMIT) begin
				slot      = head_slot;
				head_slot = chain_next[head_slot[IDX_W-1:0]];
			end else if (fresh_mark < usable) begin
				slot       = fresh_mark;
				fresh_mark = fresh_mark + 1'b1;
			end else begin
				return res;
			end
			res.block_address = ADDR_W'(longint'(pool_base) + slot * blk + HDR_BYTES);
			res.ok            = 1'b1;
			grant_cnt++;
		end else begin
			// range test in 64 bits so a pool running past 2^32 does not wrap
			start = longint'(pool_base) + HDR_BYTES;
			if (usable == 0 || longint'(addr) < start)
				return res;
			off = longint'(addr) - start;
			if (off >= usable * blk)
				return res;
			slot                        = off / blk;
			chain_next[slot[IDX_W-1:0]] = head_slot;
			head_slot                   = CNT_W'(slot);
			res.ok                      = 1'b1;
			reclaim_cnt++;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			pool_base   = fbpa_pkg::RST_POOL_BASE;
			payload_sz  = fbpa_pkg::RST_PAYLOAD_BYTES;
			slot_lim    = fbpa_pkg::RST_SLOT_COUNT;
			head_slot   = CNT_W'(fbpa_pkg::DEF_MAX_SLOTS);
			fresh_mark  = '0;
			expected_q.delete();
			fail_cnt    = 0;
			grant_cnt   = 0;
			reclaim_cnt = 0;
			pending    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (fbpa_pkg::cfg_reg_t'(cfg.index))
					fbpa_pkg::CFG_POOL_BASE:     pool_base  = cfg.data;
					fbpa_pkg::CFG_PAYLOAD_BYTES: payload_sz = cfg.data[PAY_W-1:0];
					fbpa_pkg::CFG_SLOT_COUNT:    slot_lim   = cfg.data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("response with no request outstanding: block_address %h ok %b",
						rsp.block_address, rsp.ok);
					fail_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.block_address !== want.block_address) begin
						$error("block_address: expected %h, actual %h",
							want.block_address, rsp.block_address);
						fail_cnt++;
					end
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %b, actual %b", want.ok, rsp.ok);
						fail_cnt++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(predict_request(req.func, req.address));
			pending <= expected_q.size();
		end
	end

endmodule

// ===== sim/fixed_block_pool_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Drives allocate and free requests through several pool settings, from
// directed edge cases to random traffic that frees what it was granted, with
// random stalls on both channels. The checker beside the block does the
// prediction; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;

	localparam int ADDR_W = fbpa_pkg::ADDR_W;
	localparam int PAY_W  = fbpa_pkg::PAY_W;
	localparam int CNT_W  = fbpa_pkg::CNT_W;

	localparam int DEF_MAX_SLOTS    = fbpa_pkg::DEF_MAX_SLOTS;
	localparam int DEF_HEADER_BYTES = fbpa_pkg::DEF_HEADER_BYTES;

	localparam logic FUNC_ALLOC = fbpa_pkg::FUNC_ALLOC;
	localparam logic FUNC_FREE  = fbpa_pkg::FUNC_FREE;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_TAIL  = 40;

	logic clk;
	logic arst_n;

	fbpa_cfg_if cfg_ch ();
	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();

	int failures;
	int pending;
	int grants;
	int reclaims;

	int snd_idle;
	int rcv_idle;
	int cycles;
	int items_sent;
	int settings_used;

	logic [ADDR_W-1:0] cur_base;
	logic [PAY_W-1:0]  cur_payload;
	logic [CNT_W-1:0]  cur_count;

	// granted addresses, fed back as well-formed frees
	logic [ADDR_W-1:0] held [$];
	logic              sent_funcs [$];

	fixed_block_pool_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	fbpa_alloc_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (failures),
		.pending  (pending),
		.grants   (grants),
		.reclaims (reclaims)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("fixed_block_pool_allocator: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready && sent_funcs.size() > 0) begin
			if (sent_funcs.pop_front() == FUNC_ALLOC && rsp_ch.ok)
				held.push_back(rsp_ch.block_address);
		end
	end

	// hold valid low, then wait until the checker has seen every response
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_item(input logic f, input logic [ADDR_W-1:0] a);
		while ($urandom_range(99) < snd_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.func    <= f;
		req_ch.address <= a;
		do @(posedge clk); while (!req_ch.ready);
		sent_funcs.push_back(f);
		items_sent++;
	endtask

	task automatic configure(input logic [ADDR_W-1:0] base, input logic [PAY_W-1:0] pay,
			input logic [CNT_W-1:0] cnt);
		fbpa_pkg::cfg_reg_t idx [3];
		logic [ADDR_W-1:0]  val [3];
		drain();
		idx = '{fbpa_pkg::CFG_POOL_BASE, fbpa_pkg::CFG_PAYLOAD_BYTES,
			fbpa_pkg::CFG_SLOT_COUNT};
		val = '{base, ADDR_W'(pay), ADDR_W'(cnt)};
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		cur_base    = base;
		cur_payload = pay;
		cur_count   = cnt;
		held.delete();
		settings_used++;
	endtask

	task automatic run_phase(input int n);
		longint unsigned   blk;
		longint unsigned   lim;
		longint unsigned   pool_end;
		logic [ADDR_W-1:0] a;
		int                r;
		int                pick;
		blk      = longint'(cur_payload) + DEF_HEADER_BYTES;
		lim      = (cur_count > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : cur_count;
		pool_end = longint'(cur_base) + DEF_HEADER_BYTES + lim * blk;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain();
			if ($urandom_range(99) < 50) begin
				send_item(FUNC_ALLOC, $urandom);
			end else begin
				r = $urandom_range(99);
				if (r < 55 && held.size() > 0) begin
					pick = $urandom_range(held.size() - 1);
					a    = held[pick];
					held.delete(pick);
					// mostly inside the payload; now and then back into the header
					if ($urandom_range(4) == 0)
						a = a - $urandom_range(16, 1);
					else
						a = a + $urandom_range(cur_payload - 1);
				end else if (r < 85 && lim > 0) begin
					a = ADDR_W'(longint'(cur_base) + DEF_HEADER_BYTES
						+ $urandom_range(32'(lim - 1)) * blk + $urandom_range(32'(blk - 1)));
				end else begin
					case ($urandom_range(3))
						0: a = $urandom;
						1: a = cur_base + DEF_HEADER_BYTES - 1;
						2: a = ADDR_W'(pool_end);
						default: a = ADDR_W'(pool_end - 1);
					endcase
				end
				send_item(FUNC_FREE, a);
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cycles         = 0;
		items_sent     = 0;
		settings_used  = 0;
		snd_idle       = 11;
		rcv_idle       = 82;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = fbpa_pkg::CFG_POOL_BASE;
		cfg_ch.data    = '0;
		req_ch.valid   = 1'b0;
		req_ch.func    = FUNC_ALLOC;
		req_ch.address = '0;
		rsp_ch.ready   = 1'b0;
		cur_base       = fbpa_pkg::RST_POOL_BASE;
		cur_payload    = fbpa_pkg::RST_PAYLOAD_BYTES;
		cur_count      = fbpa_pkg::RST_SLOT_COUNT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pool: base 0, 80-byte blocks, 256 slots, payloads from 16
		send_item(FUNC_ALLOC, 32'h0000_0000);
		send_item(FUNC_ALLOC, 32'hFFFF_FFFF);
		send_item(FUNC_ALLOC, 32'h0000_0000);
		send_item(FUNC_FREE, 32'd101);           // unaligned, slot 1
		send_item(FUNC_FREE, 32'd16);
		send_item(FUNC_FREE, 32'd16);            // double free, pushed again
		send_item(FUNC_FREE, 32'd0);             // below the pool
		send_item(FUNC_FREE, 32'd15);            // inside slot 0's header
		send_item(FUNC_FREE, 32'd20496);         // one past the end
		send_item(FUNC_FREE, 32'd20495);         // last byte, never granted
		send_item(FUNC_FREE, 32'hFFFF_FFFF);
		repeat (4) send_item(FUNC_ALLOC, $urandom);
		send_item(FUNC_ALLOC, $urandom);         // slot 0 again: the double free linked it to itself

		// pool starts right at 2^32: nothing can be freed, nothing fresh left
		configure(32'hFFFF_FFF0, 16'hFFFF, 9'd2);
		send_item(FUNC_ALLOC, $urandom);
		send_item(FUNC_FREE, 32'h0000_0000);
		send_item(FUNC_FREE, 32'hFFFF_FFFF);

		// empty pool
		configure(32'h0000_0000, 16'd1, 9'd0);
		send_item(FUNC_ALLOC, $urandom);
		send_item(FUNC_FREE, 32'd16);

		configure(32'h1000_0000, 16'd64, 9'd8);
		run_phase(100);
		configure(32'hFFFF_FF00, 16'hFFFF, 9'd256);
		run_phase(100);
		configure(32'h0000_0000, 16'd1, 9'd1);
		run_phase(100);

		snd_idle = 82;
		rcv_idle = 11;
		configure($urandom, PAY_W'($urandom_range(300, 1)), CNT_W'($urandom_range(16, 1)));
		run_phase(100);
		configure(32'hFFFF_FFFF, 16'd1, 9'd511);
		run_phase(100);
		configure($urandom, PAY_W'($urandom_range(65535, 1)), CNT_W'($urandom_range(256, 1)));
		run_phase(100);

		snd_idle = 0;
		rcv_idle = 0;
		configure($urandom, 16'd48, 9'd0);
		run_phase(20);
		configure($urandom, PAY_W'($urandom_range(128, 1)), CNT_W'($urandom_range(32, 1)));
		run_phase(180);

		drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("%0d requests over %0d pool settings; %0d grants and %0d reclaims predicted",
			items_sent, settings_used, grants, reclaims);
		if (failures == 0 && pending == 0)
			$display("fixed_block_pool_allocator: match");
		else
			$display("fixed_block_pool_allocator: mismatch");
		$finish;
	end

endmodule
